### rtl/core/multi_channel_uart_byte_fifo_unit_macros.svh
// Assertion macros shared by the byte FIFO unit modules.
`ifndef MULTI_CHANNEL_UART_BYTE_FIFO_UNIT_MACROS_SVH
`define MULTI_CHANNEL_UART_BYTE_FIFO_UNIT_MACROS_SVH

// Check that cond holds in the same cycle as trig.
`define MCUF_ASSERT_IMPLY(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("mcuf assertion failed: same-cycle implication");

// Check that cond holds in the cycle after trig.
`define MCUF_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("mcuf assertion failed: next-cycle implication");

`endif

### rtl/core/mcuf_pkg.sv
// Types and constants of the multi-channel byte FIFO unit.
package mcuf_pkg;

   localparam int MODE_W   = 3;
   localparam int CHAN_W   = 2;
   localparam int BYTE_W   = 8;
   localparam int BLEN_W   = 7;
   localparam int STATUS_W = 2;
   localparam int USED_W   = 7;

   typedef enum logic [MODE_W-1:0] {
      MODE_RX_PUT  = 3'd0,
      MODE_RX_GET  = 3'd1,
      MODE_RX_PEEK = 3'd2,
      MODE_TX_PUT  = 3'd3,
      MODE_TX_GET  = 3'd4,
      MODE_QUERY   = 3'd5
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NO_CHANNEL = 2'd1,
      STATUS_EMPTY_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_item;
      logic execute;
   } cmd_type;

endpackage

### rtl/core/mcuf_ifs.sv
// Request and response channel interfaces of the byte FIFO unit.
interface mcuf_req_if;
   logic                             valid;
   logic                             ready;
   logic [mcuf_pkg::MODE_W-1:0]      mode;
   logic [mcuf_pkg::CHAN_W-1:0]      channel;
   logic [mcuf_pkg::BYTE_W-1:0]      data_byte;
   logic [mcuf_pkg::BLEN_W-1:0]      burst_len;
   logic                             first_of_burst;

   modport source (output valid, mode, channel, data_byte, burst_len, first_of_burst,
                   input ready);
   modport sink (input valid, mode, channel, data_byte, burst_len, first_of_burst,
                 output ready);
endinterface

interface mcuf_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [mcuf_pkg::STATUS_W-1:0]    status;
   logic [mcuf_pkg::BYTE_W-1:0]      data_out;
   logic [mcuf_pkg::USED_W-1:0]      rx_used;
   logic [mcuf_pkg::USED_W-1:0]      tx_used;
   logic                             tx_irq_enable;

   modport source (output valid, status, data_out, rx_used, tx_used, tx_irq_enable,
                   input ready);
   modport sink (input valid, status, data_out, rx_used, tx_used, tx_irq_enable,
                 output ready);
endinterface

### rtl/core/mcuf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mcuf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/mcuf_ctrl.sv
// Controller state machine: sequences load, execute and response of one item.
`include "multi_channel_uart_byte_fifo_unit_macros.svh"

module mcuf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mcuf_pkg::cmd_type cmd
);

   mcuf_pkg::state_type state_ff, state_in;

   // Hold the state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mcuf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands; refuse items while reset is held
   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      rsp_valid     = 1'b0;
      cmd.load_item = 1'b0;
      cmd.execute   = 1'b0;
      case (state_ff)
         mcuf_pkg::ST_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load_item = 1'b1;
               state_in      = mcuf_pkg::ST_EXEC;
            end
         end
         mcuf_pkg::ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = mcuf_pkg::ST_RESP;
         end
         mcuf_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = mcuf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mcuf_pkg::ST_IDLE;
         end
      endcase
   end

   // One item in flight at a time
   `MCUF_ASSERT_IMPLY(a_no_accept_while_rsp, clock, reset, rsp_valid, !req_ready)
   `MCUF_ASSERT_NEXT(a_load_then_exec, clock, reset, cmd.load_item, cmd.execute)
   `MCUF_ASSERT_NEXT(a_exec_then_rsp, clock, reset, cmd.execute, rsp_valid)

endmodule

### rtl/core/mcuf_dp.sv
// Datapath: item register, per-channel pointers and counts, byte stores, result register.
`include "multi_channel_uart_byte_fifo_unit_macros.svh"

module mcuf_dp #(
   parameter int CHANNELS = 3,
   parameter int RX_DEPTH = 64,
   parameter int TX_DEPTH = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  mcuf_pkg::cmd_type               cmd,
   input  logic [mcuf_pkg::MODE_W-1:0]     mode,
   input  logic [mcuf_pkg::CHAN_W-1:0]     channel,
   input  logic [mcuf_pkg::BYTE_W-1:0]     data_byte,
   input  logic [mcuf_pkg::BLEN_W-1:0]     burst_len,
   input  logic                            first_of_burst,
   output logic [mcuf_pkg::STATUS_W-1:0]   status,
   output logic [mcuf_pkg::BYTE_W-1:0]     data_out,
   output logic [mcuf_pkg::USED_W-1:0]     rx_used,
   output logic [mcuf_pkg::USED_W-1:0]     tx_used,
   output logic                            tx_irq_enable
);

   localparam int RX_PW = $clog2(RX_DEPTH);
   localparam int RX_CW = $clog2(RX_DEPTH + 1);
   localparam int RX_AW = $clog2(CHANNELS * RX_DEPTH);
   localparam int TX_PW = $clog2(TX_DEPTH);
   localparam int TX_CW = $clog2(TX_DEPTH + 1);
   localparam int TX_AW = $clog2(CHANNELS * TX_DEPTH);

   typedef enum logic [1:0] {
      RD_NONE,
      RD_RX,
      RD_TX
   } rd_sel_type;

   // Item register
   logic [mcuf_pkg::MODE_W-1:0] mode_ff;
   logic [mcuf_pkg::CHAN_W-1:0] chan_ff;
   logic [mcuf_pkg::BYTE_W-1:0] byte_ff;
   logic [mcuf_pkg::BLEN_W-1:0] blen_ff;
   logic                        first_ff;

   // Per-channel control state
   logic [RX_PW-1:0] rx_head_ff [CHANNELS];
   logic [RX_PW-1:0] rx_tail_ff [CHANNELS];
   logic [RX_CW-1:0] rx_cnt_ff  [CHANNELS];
   logic [TX_PW-1:0] tx_head_ff [CHANNELS];
   logic [TX_PW-1:0] tx_tail_ff [CHANNELS];
   logic [TX_CW-1:0] tx_cnt_ff  [CHANNELS];
   logic             irq_ff     [CHANNELS];
   logic             drop_ff    [CHANNELS];

   // Selected channel, current and next
   logic             ch_ok;
   logic [RX_PW-1:0] cur_rx_head, cur_rx_tail, rx_head_in, rx_tail_in;
   logic [RX_CW-1:0] cur_rx_cnt, rx_cnt_in;
   logic [TX_PW-1:0] cur_tx_head, cur_tx_tail, tx_head_in, tx_tail_in;
   logic [TX_CW-1:0] cur_tx_cnt, tx_cnt_in;
   logic             cur_irq, cur_drop, irq_in, drop_in;

   // Store control
   logic             rx_wr, rx_rd, tx_wr, tx_rd, tx_store;
   logic [RX_AW-1:0] rx_wr_addr, rx_rd_addr;
   logic [TX_AW-1:0] tx_wr_addr, tx_rd_addr;
   logic [mcuf_pkg::BYTE_W-1:0] rx_rd_data, tx_rd_data;

   // Result register
   mcuf_pkg::status_type        status_in;
   logic [mcuf_pkg::STATUS_W-1:0] status_ff;
   logic [mcuf_pkg::USED_W-1:0] rx_used_ff, tx_used_ff;
   logic                        irq_out_ff;
   rd_sel_type                  rd_sel_ff, rd_sel_in;

   // Capture the accepted item
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         mode_ff  <= mode;
         chan_ff  <= channel;
         byte_ff  <= data_byte;
         blen_ff  <= burst_len;
         first_ff <= first_of_burst;
      end
   end

   // Select the addressed channel's state
   always_comb begin
      ch_ok       = 32'(chan_ff) < CHANNELS;
      cur_rx_head = '0;
      cur_rx_tail = '0;
      cur_rx_cnt  = '0;
      cur_tx_head = '0;
      cur_tx_tail = '0;
      cur_tx_cnt  = '0;
      cur_irq     = 1'b0;
      cur_drop    = 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
         if (32'(chan_ff) == c) begin
            cur_rx_head = rx_head_ff[c];
            cur_rx_tail = rx_tail_ff[c];
            cur_rx_cnt  = rx_cnt_ff[c];
            cur_tx_head = tx_head_ff[c];
            cur_tx_tail = tx_tail_ff[c];
            cur_tx_cnt  = tx_cnt_ff[c];
            cur_irq     = irq_ff[c];
            cur_drop    = drop_ff[c];
         end
      end
   end

   // Decode the operation and work out the channel's next state
   always_comb begin
      rx_head_in = cur_rx_head;
      rx_tail_in = cur_rx_tail;
      rx_cnt_in  = cur_rx_cnt;
      tx_head_in = cur_tx_head;
      tx_tail_in = cur_tx_tail;
      tx_cnt_in  = cur_tx_cnt;
      irq_in     = cur_irq;
      drop_in    = cur_drop;
      status_in  = mcuf_pkg::STATUS_OK;
      rd_sel_in  = RD_NONE;
      rx_wr      = 1'b0;
      rx_rd      = 1'b0;
      tx_rd      = 1'b0;
      tx_store   = 1'b0;
      if (!ch_ok) begin
         status_in = mcuf_pkg::STATUS_NO_CHANNEL;
      end else begin
         case (mode_ff)
            mcuf_pkg::MODE_RX_PUT: begin
               if (cur_rx_cnt >= RX_CW'(RX_DEPTH)) begin
                  status_in = mcuf_pkg::STATUS_EMPTY_FULL;
               end else begin
                  rx_wr      = 1'b1;
                  rx_head_in = (cur_rx_head == RX_PW'(RX_DEPTH - 1)) ? '0
                                                                     : cur_rx_head + 1'b1;
                  rx_cnt_in  = cur_rx_cnt + 1'b1;
               end
            end
            mcuf_pkg::MODE_RX_GET, mcuf_pkg::MODE_RX_PEEK: begin
               if (cur_rx_cnt == '0) begin
                  status_in = mcuf_pkg::STATUS_EMPTY_FULL;
               end else begin
                  rx_rd     = 1'b1;
                  rd_sel_in = RD_RX;
                  if (mode_ff == mcuf_pkg::MODE_RX_GET) begin
                     rx_tail_in = (cur_rx_tail == RX_PW'(RX_DEPTH - 1)) ? '0
                                                                        : cur_rx_tail + 1'b1;
                     rx_cnt_in  = cur_rx_cnt - 1'b1;
                  end
               end
            end
            mcuf_pkg::MODE_TX_PUT: begin
               if (first_ff) begin
                  // Admit or refuse the whole burst on its first byte
                  if (32'(cur_tx_cnt) + 32'(blen_ff) < TX_DEPTH) begin
                     drop_in  = 1'b0;
                     tx_store = 1'b1;
                  end else begin
                     drop_in   = 1'b1;
                     status_in = mcuf_pkg::STATUS_EMPTY_FULL;
                  end
               end else if (cur_drop || cur_tx_cnt >= TX_CW'(TX_DEPTH)) begin
                  status_in = mcuf_pkg::STATUS_EMPTY_FULL;
               end else begin
                  tx_store = 1'b1;
               end
               if (tx_store) begin
                  tx_head_in = (cur_tx_head == TX_PW'(TX_DEPTH - 1)) ? '0
                                                                     : cur_tx_head + 1'b1;
                  tx_cnt_in  = cur_tx_cnt + 1'b1;
                  if (cur_tx_cnt == '0) begin
                     irq_in = 1'b1;
                  end
               end
            end
            mcuf_pkg::MODE_TX_GET: begin
               if (cur_tx_cnt == '0) begin
                  status_in = mcuf_pkg::STATUS_EMPTY_FULL;
                  irq_in    = 1'b0;
               end else begin
                  tx_rd      = 1'b1;
                  rd_sel_in  = RD_TX;
                  tx_tail_in = (cur_tx_tail == TX_PW'(TX_DEPTH - 1)) ? '0
                                                                     : cur_tx_tail + 1'b1;
                  tx_cnt_in  = cur_tx_cnt - 1'b1;
               end
            end
            default: begin
               // query and unused codes leave state alone
            end
         endcase
      end
      tx_wr = tx_store;
   end

   // Flat store addresses: channel block plus pointer
   assign rx_wr_addr = RX_AW'(32'(chan_ff) * RX_DEPTH + 32'(cur_rx_head));
   assign rx_rd_addr = RX_AW'(32'(chan_ff) * RX_DEPTH + 32'(cur_rx_tail));
   assign tx_wr_addr = TX_AW'(32'(chan_ff) * TX_DEPTH + 32'(cur_tx_head));
   assign tx_rd_addr = TX_AW'(32'(chan_ff) * TX_DEPTH + 32'(cur_tx_tail));

   // Write back the addressed channel
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            rx_head_ff[c] <= '0;
            rx_tail_ff[c] <= '0;
            rx_cnt_ff[c]  <= '0;
            tx_head_ff[c] <= '0;
            tx_tail_ff[c] <= '0;
            tx_cnt_ff[c]  <= '0;
            irq_ff[c]     <= 1'b0;
            drop_ff[c]    <= 1'b0;
         end
      end else if (cmd.execute && ch_ok) begin
         for (int c = 0; c < CHANNELS; c++) begin
            if (32'(chan_ff) == c) begin
               rx_head_ff[c] <= rx_head_in;
               rx_tail_ff[c] <= rx_tail_in;
               rx_cnt_ff[c]  <= rx_cnt_in;
               tx_head_ff[c] <= tx_head_in;
               tx_tail_ff[c] <= tx_tail_in;
               tx_cnt_ff[c]  <= tx_cnt_in;
               irq_ff[c]     <= irq_in;
               drop_ff[c]    <= drop_in;
            end
         end
      end
   end

   // Register the result fields
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff  <= status_in;
         rd_sel_ff  <= rd_sel_in;
         rx_used_ff <= ch_ok ? mcuf_pkg::USED_W'(rx_cnt_in) : '0;
         tx_used_ff <= ch_ok ? mcuf_pkg::USED_W'(tx_cnt_in) : '0;
         irq_out_ff <= ch_ok ? irq_in : 1'b0;
      end
   end

   mcuf_ram #(
      .WIDTH (mcuf_pkg::BYTE_W),
      .DEPTH (CHANNELS * RX_DEPTH)
   ) u_rx_ram (
      .clock   (clock),
      .wr_en   (cmd.execute && rx_wr),
      .wr_addr (rx_wr_addr),
      .wr_data (byte_ff),
      .rd_en   (cmd.execute && rx_rd),
      .rd_addr (rx_rd_addr),
      .rd_data (rx_rd_data)
   );

   mcuf_ram #(
      .WIDTH (mcuf_pkg::BYTE_W),
      .DEPTH (CHANNELS * TX_DEPTH)
   ) u_tx_ram (
      .clock   (clock),
      .wr_en   (cmd.execute && tx_wr),
      .wr_addr (tx_wr_addr),
      .wr_data (byte_ff),
      .rd_en   (cmd.execute && tx_rd),
      .rd_addr (tx_rd_addr),
      .rd_data (tx_rd_data)
   );

   // Drive the result
   always_comb begin
      case (rd_sel_ff)
         RD_RX:   data_out = rx_rd_data;
         RD_TX:   data_out = tx_rd_data;
         default: data_out = '0;
      endcase
   end

   assign status        = status_ff;
   assign rx_used       = rx_used_ff;
   assign tx_used       = tx_used_ff;
   assign tx_irq_enable = irq_out_ff;

   // Counts never pass the buffer depth
   for (genvar g = 0; g < CHANNELS; g++) begin : g_cnt_chk
      `MCUF_ASSERT_IMPLY(a_rx_cnt_bound, clock, reset, 1'b1, rx_cnt_ff[g] <= RX_CW'(RX_DEPTH))
      `MCUF_ASSERT_IMPLY(a_tx_cnt_bound, clock, reset, 1'b1, tx_cnt_ff[g] <= TX_CW'(TX_DEPTH))
   end

endmodule

### rtl/core/multi_channel_uart_byte_fifo_unit.sv
// Top level of the multi-channel receive/transmit byte FIFO unit.
//
//   channel   direction  contents
//   req_ch    in         mode, channel, data_byte, burst_len, first_of_burst
//   rsp_ch    out        status, data_out, rx_used, tx_used, tx_irq_enable
//
// An item goes through accept, execute (state update and store access), then
// the offer of the result. The registered read port of the byte stores has its
// data ready for the result. A stalled result holds the unit until it is taken.
// Synchronous reset clears all pointers, counts and flags; stores are not cleared.
module multi_channel_uart_byte_fifo_unit #(
   parameter int CHANNELS = 3,
   parameter int RX_DEPTH = 64,
   parameter int TX_DEPTH = 64
) (
   input logic        clock,
   input logic        reset,
   mcuf_req_if.sink   req_ch,
   mcuf_rsp_if.source rsp_ch
);

   mcuf_pkg::cmd_type cmd;

   mcuf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   mcuf_dp #(
      .CHANNELS (CHANNELS),
      .RX_DEPTH (RX_DEPTH),
      .TX_DEPTH (TX_DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .mode           (req_ch.mode),
      .channel        (req_ch.channel),
      .data_byte      (req_ch.data_byte),
      .burst_len      (req_ch.burst_len),
      .first_of_burst (req_ch.first_of_burst),
      .status         (rsp_ch.status),
      .data_out       (rsp_ch.data_out),
      .rx_used        (rsp_ch.rx_used),
      .tx_used        (rsp_ch.tx_used),
      .tx_irq_enable  (rsp_ch.tx_irq_enable)
   );

endmodule

### tb/tb.sv
// Self-checking testbench of the multi-channel receive/transmit byte FIFO unit.
`timescale 1ns / 100ps

localparam int FIFO_CHANNELS = 3;
localparam int FIFO_RX_DEPTH = 64;
localparam int FIFO_TX_DEPTH = 64;

// Unused mode codes act as a query; the top channel code is never populated.
localparam logic [mcuf_pkg::MODE_W-1:0] MODE_SPARE_6    = 3'd6;
localparam logic [mcuf_pkg::MODE_W-1:0] MODE_SPARE_7    = 3'd7;
localparam logic [mcuf_pkg::CHAN_W-1:0] INVALID_CHANNEL = 2'd3;

typedef struct packed {
   mcuf_pkg::status_type          status;
   logic [mcuf_pkg::BYTE_W-1:0]   data_out;
   logic [mcuf_pkg::USED_W-1:0]   rx_used;
   logic [mcuf_pkg::USED_W-1:0]   tx_used;
   logic                          tx_irq_enable;
} fifo_result_type;

// Shadow copy of the per-channel rings and the queue of results still owed.
class fifo_scoreboard;
   logic [mcuf_pkg::BYTE_W-1:0] rx_ring [FIFO_CHANNELS][FIFO_RX_DEPTH];
   logic [mcuf_pkg::BYTE_W-1:0] tx_ring [FIFO_CHANNELS][FIFO_TX_DEPTH];
   int                rx_wr [FIFO_CHANNELS];
   int                rx_rd [FIFO_CHANNELS];
   int                rx_level [FIFO_CHANNELS];
   int                tx_wr [FIFO_CHANNELS];
   int                tx_rd [FIFO_CHANNELS];
   int                tx_level [FIFO_CHANNELS];
   bit                irq_en [FIFO_CHANNELS];
   bit                dropping [FIFO_CHANNELS];
   fifo_result_type   owed [$];
   int                errors;

   function new();
      for (int c = 0; c < FIFO_CHANNELS; c++) begin
         rx_wr[c] = 0;
         rx_rd[c] = 0;
         rx_level[c] = 0;
         tx_wr[c] = 0;
         tx_rd[c] = 0;
         tx_level[c] = 0;
         irq_en[c] = 1'b0;
         dropping[c] = 1'b0;
      end
      errors = 0;
   endfunction

   // Append to the transmit ring; the first byte into an empty ring arms the irq.
   function void push_tx(int c, logic [mcuf_pkg::BYTE_W-1:0] b);
      tx_ring[c][tx_wr[c]] = b;
      tx_wr[c] = (tx_wr[c] + 1 >= FIFO_TX_DEPTH) ? 0 : tx_wr[c] + 1;
      tx_level[c]++;
      if (tx_level[c] == 1)
         irq_en[c] = 1'b1;
   endfunction

   // Work out the result of one accepted item and queue it.
   function void note_request(logic [mcuf_pkg::MODE_W-1:0] mode,
                              logic [mcuf_pkg::CHAN_W-1:0] ch,
                              logic [mcuf_pkg::BYTE_W-1:0] b,
                              logic [mcuf_pkg::BLEN_W-1:0] blen,
                              logic first);
      fifo_result_type r;
      int              c;
      r = '0;
      r.status = mcuf_pkg::STATUS_OK;
      c = int'(ch);
      if (c >= FIFO_CHANNELS) begin
         r.status = mcuf_pkg::STATUS_NO_CHANNEL;
         owed.push_back(r);
         return;
      end
      case (mode)
         mcuf_pkg::MODE_RX_PUT: begin
            if (rx_level[c] >= FIFO_RX_DEPTH) begin
               r.status = mcuf_pkg::STATUS_EMPTY_FULL;
            end else begin
               rx_ring[c][rx_wr[c]] = b;
               rx_wr[c] = (rx_wr[c] + 1 >= FIFO_RX_DEPTH) ? 0 : rx_wr[c] + 1;
               rx_level[c]++;
            end
         end
         mcuf_pkg::MODE_RX_GET, mcuf_pkg::MODE_RX_PEEK: begin
            if (rx_level[c] == 0) begin
               r.status = mcuf_pkg::STATUS_EMPTY_FULL;
            end else begin
               r.data_out = rx_ring[c][rx_rd[c]];
               if (mode == mcuf_pkg::MODE_RX_GET) begin
                  rx_rd[c] = (rx_rd[c] + 1 >= FIFO_RX_DEPTH) ? 0 : rx_rd[c] + 1;
                  rx_level[c]--;
               end
            end
         end
         mcuf_pkg::MODE_TX_PUT: begin
            // Admit or refuse a whole burst on its first byte.
            if (first) begin
               if (tx_level[c] + int'(blen) < FIFO_TX_DEPTH) begin
                  dropping[c] = 1'b0;
                  push_tx(c, b);
               end else begin
                  dropping[c] = 1'b1;
                  r.status = mcuf_pkg::STATUS_EMPTY_FULL;
               end
            end else if (dropping[c] || tx_level[c] >= FIFO_TX_DEPTH) begin
               r.status = mcuf_pkg::STATUS_EMPTY_FULL;
            end else begin
               push_tx(c, b);
            end
         end
         mcuf_pkg::MODE_TX_GET: begin
            if (tx_level[c] == 0) begin
               r.status = mcuf_pkg::STATUS_EMPTY_FULL;
               irq_en[c] = 1'b0;
            end else begin
               r.data_out = tx_ring[c][tx_rd[c]];
               tx_rd[c] = (tx_rd[c] + 1 >= FIFO_TX_DEPTH) ? 0 : tx_rd[c] + 1;
               tx_level[c]--;
            end
         end
         default: ;
      endcase
      r.rx_used = mcuf_pkg::USED_W'(rx_level[c]);
      r.tx_used = mcuf_pkg::USED_W'(tx_level[c]);
      r.tx_irq_enable = irq_en[c];
      owed.push_back(r);
   endfunction

   // Compare one accepted result with the oldest owed result.
   function void check_response(fifo_result_type got);
      fifo_result_type want;
      if (owed.size() == 0) begin
         $error("result arrived with no item outstanding");
         errors++;
         return;
      end
      want = owed.pop_front();
      if (got.status != want.status) begin
         $error("status: expected %0d, got %0d", want.status, got.status);
         errors++;
      end
      if (got.data_out != want.data_out) begin
         $error("data_out: expected %0d, got %0d", want.data_out, got.data_out);
         errors++;
      end
      if (got.rx_used != want.rx_used) begin
         $error("rx_used: expected %0d, got %0d", want.rx_used, got.rx_used);
         errors++;
      end
      if (got.tx_used != want.tx_used) begin
         $error("tx_used: expected %0d, got %0d", want.tx_used, got.tx_used);
         errors++;
      end
      if (got.tx_irq_enable != want.tx_irq_enable) begin
         $error("tx_irq_enable: expected %0d, got %0d",
                want.tx_irq_enable, got.tx_irq_enable);
         errors++;
      end
   endfunction
endclass

module tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 800;
   localparam int HOLD_CYCLES  = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mcuf_req_if req_ch ();
   mcuf_rsp_if rsp_ch ();

   fifo_scoreboard sb = new();

   int cycle_count = 0;
   int random_sent = 0;
   bit steady      = 1'b0;
   bit hold_req    = 1'b0;
   bit hold_issued = 1'b0;

   multi_channel_uart_byte_fifo_unit #(
      .CHANNELS(FIFO_CHANNELS),
      .RX_DEPTH(FIFO_RX_DEPTH),
      .TX_DEPTH(FIFO_TX_DEPTH)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always #10 clock = ~clock;

   // Bound the run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Offer one item after a random gap and hold it until accepted.
   task automatic send_item(input logic [mcuf_pkg::MODE_W-1:0] mode,
                            input logic [mcuf_pkg::CHAN_W-1:0] ch,
                            input logic [mcuf_pkg::BYTE_W-1:0] b,
                            input logic [mcuf_pkg::BLEN_W-1:0] blen,
                            input logic first);
      while (!steady && $urandom_range(99) < 25) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.mode           <= mode;
      req_ch.channel        <= ch;
      req_ch.data_byte      <= b;
      req_ch.burst_len      <= blen;
      req_ch.first_of_burst <= first;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(mode, ch, b, blen, first);
   endtask

   function automatic logic [mcuf_pkg::CHAN_W-1:0] pick_channel();
      if ($urandom_range(11) == 0)
         return INVALID_CHANNEL;
      return mcuf_pkg::CHAN_W'($urandom_range(FIFO_CHANNELS - 1));
   endfunction

   function automatic logic [mcuf_pkg::BYTE_W-1:0] any_byte();
      return mcuf_pkg::BYTE_W'($urandom_range(255));
   endfunction

   function automatic logic [mcuf_pkg::BLEN_W-1:0] any_blen();
      return mcuf_pkg::BLEN_W'($urandom_range(127));
   endfunction

   // Run of receive puts, pushing a channel toward full.
   task automatic fill_rx(input logic [mcuf_pkg::CHAN_W-1:0] ch, input int n);
      for (int i = 0; i < n; i++) begin
         send_item(mcuf_pkg::MODE_RX_PUT, ch, any_byte(), any_blen(),
                   1'($urandom_range(1)));
         random_sent++;
      end
   endtask

   // Run of receive gets with the odd peek mixed in.
   task automatic drain_rx(input logic [mcuf_pkg::CHAN_W-1:0] ch, input int n);
      logic [mcuf_pkg::MODE_W-1:0] m;
      for (int i = 0; i < n; i++) begin
         m = ($urandom_range(3) == 0) ? mcuf_pkg::MODE_RX_PEEK : mcuf_pkg::MODE_RX_GET;
         send_item(m, ch, any_byte(), any_blen(), 1'($urandom_range(1)));
         random_sent++;
      end
   endtask

   // Transmit burst; sometimes the declared length or the byte count is off.
   task automatic burst_tx(input logic [mcuf_pkg::CHAN_W-1:0] ch);
      int                          len;
      int                          sent;
      logic [mcuf_pkg::BLEN_W-1:0] declared;
      len = ($urandom_range(4) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 16);
      declared = mcuf_pkg::BLEN_W'(len);
      sent = len;
      if ($urandom_range(9) == 0)
         declared = any_blen();
      if ($urandom_range(9) == 0)
         sent = $urandom_range(1, 70);
      send_item(mcuf_pkg::MODE_TX_PUT, ch, any_byte(), declared, 1'b1);
      random_sent++;
      for (int i = 1; i < sent; i++) begin
         send_item(mcuf_pkg::MODE_TX_PUT, ch, any_byte(), any_blen(), 1'b0);
         random_sent++;
      end
   endtask

   // Run of transmit gets, often running past empty.
   task automatic drain_tx(input logic [mcuf_pkg::CHAN_W-1:0] ch, input int n);
      for (int i = 0; i < n; i++) begin
         send_item(mcuf_pkg::MODE_TX_GET, ch, any_byte(), any_blen(),
                   1'($urandom_range(1)));
         random_sent++;
      end
   endtask

   // Receive side: check each taken result, stall at random, and hold off on request.
   initial begin
      int   hold_left;
      logic take;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            sb.check_response('{mcuf_pkg::status_type'(rsp_ch.status), rsp_ch.data_out,
                                rsp_ch.rx_used, rsp_ch.tx_used, rsp_ch.tx_irq_enable});
         if (hold_left > 0) begin
            hold_left--;
            take = 1'b0;
         end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
            take = 1'b0;
         end else begin
            take = steady || ($urandom_range(99) >= 25);
         end
         rsp_ch.ready <= take;
      end
   end

   // Stimulus and end of run.
   initial begin
      int                          kind;
      logic [mcuf_pkg::CHAN_W-1:0] ch;
      req_ch.valid          <= 1'b0;
      req_ch.mode           <= mcuf_pkg::MODE_QUERY;
      req_ch.channel        <= '0;
      req_ch.data_byte      <= '0;
      req_ch.burst_len      <= '0;
      req_ch.first_of_burst <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty reads, bad channel, spare modes, byte extremes.
      send_item(mcuf_pkg::MODE_QUERY,   2'd0, 8'h00, 7'd1, 1'b0);
      send_item(mcuf_pkg::MODE_RX_GET,  2'd0, 8'hff, 7'd1, 1'b0);
      send_item(mcuf_pkg::MODE_RX_PEEK, 2'd0, 8'h00, 7'd1, 1'b0);
      send_item(mcuf_pkg::MODE_TX_GET,  2'd0, 8'h00, 7'd1, 1'b0);
      send_item(mcuf_pkg::MODE_RX_PUT,  INVALID_CHANNEL, 8'hff, 7'd127, 1'b1);
      send_item(mcuf_pkg::MODE_TX_GET,  INVALID_CHANNEL, 8'h00, 7'd0, 1'b0);
      send_item(MODE_SPARE_6,           2'd1, 8'h5a, 7'd3, 1'b0);
      send_item(MODE_SPARE_7,           2'd2, 8'ha5, 7'd3, 1'b1);
      send_item(mcuf_pkg::MODE_RX_PUT,  2'd0, 8'hff, 7'd0, 1'b0);
      send_item(mcuf_pkg::MODE_RX_PUT,  2'd0, 8'h00, 7'd0, 1'b1);
      send_item(mcuf_pkg::MODE_RX_PEEK, 2'd0, 8'h00, 7'd0, 1'b0);
      send_item(mcuf_pkg::MODE_RX_GET,  2'd0, 8'h00, 7'd0, 1'b0);
      send_item(mcuf_pkg::MODE_RX_GET,  2'd0, 8'h00, 7'd0, 1'b0);
      // Burst admission: zero length fits, a too-long burst is refused and its tail
      // dropped, then a burst that just fits is taken.
      send_item(mcuf_pkg::MODE_TX_PUT,  2'd1, 8'ha5, 7'd0, 1'b1);
      send_item(mcuf_pkg::MODE_TX_PUT,  2'd1, 8'h11, 7'd127, 1'b1);
      send_item(mcuf_pkg::MODE_TX_PUT,  2'd1, 8'h22, 7'd0, 1'b0);
      send_item(mcuf_pkg::MODE_TX_PUT,  2'd1, 8'hff, 7'd62, 1'b1);
      send_item(mcuf_pkg::MODE_TX_PUT,  2'd2, 8'h00, 7'd63, 1'b1);
      send_item(mcuf_pkg::MODE_TX_PUT,  2'd2, 8'h33, 7'd64, 1'b1);
      // Drain past empty to clear the irq enable.
      send_item(mcuf_pkg::MODE_TX_GET,  2'd1, 8'h00, 7'd0, 1'b0);
      send_item(mcuf_pkg::MODE_TX_GET,  2'd1, 8'h00, 7'd0, 1'b0);
      send_item(mcuf_pkg::MODE_TX_GET,  2'd1, 8'h00, 7'd0, 1'b0);
      send_item(mcuf_pkg::MODE_QUERY,   2'd1, 8'h00, 7'd0, 1'b0);

      // Random: mostly well-formed runs and bursts, the rest noise.
      while (random_sent < RANDOM_ITEMS) begin
         // Ask the receiver for one long hold once the run is under way.
         if (random_sent >= 120 && !hold_issued) begin
            hold_req    = 1'b1;
            hold_issued = 1'b1;
         end
         steady = (random_sent >= 400 && random_sent < 550);
         ch = pick_channel();
         kind = $urandom_range(99);
         if (kind < 20)
            fill_rx(ch, $urandom_range(1, 80));
         else if (kind < 38)
            drain_rx(ch, $urandom_range(1, 70));
         else if (kind < 63)
            burst_tx(ch);
         else if (kind < 78)
            drain_tx(ch, $urandom_range(1, 40));
         else begin
            send_item(mcuf_pkg::MODE_W'($urandom_range(7)),
                      mcuf_pkg::CHAN_W'($urandom_range(3)), any_byte(),
                      any_blen(), 1'($urandom_range(1)));
            random_sent++;
         end
      end
      steady = 1'b0;
      req_ch.valid <= 1'b0;

      // Wait for every owed result, then a few more cycles for stray ones.
      while (sb.owed.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.owed.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
